### hdl/bpec_pkg.sv
// Shared types and constants for the button press event classifier.
// Depends on nothing; imported by bpec_core and button_press_event_classifier.
package bpec_pkg;

    localparam int TIME_BITS    = 48;
    localparam int GAP_BITS     = 32;
    localparam int CFG_IDX_BITS = 1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [GAP_BITS-1:0]  t_gap;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LONG_GAP  = 1'b0,
        CFG_SHORT_GAP = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_gap long_gap;
        t_gap short_gap;
    } t_gaps;

    typedef struct packed {
        logic level_changed;
        logic state_reversed;
        logic became_pressed;
        logic became_released;
        logic long_release_ended;
        logic short_release_ended;
        logic long_press_ended;
        logic short_press_ended;
        logic long_press_entered;
        logic long_press_holding;
        logic long_release_entered;
        logic long_release_holding;
    } t_flags;

    // True when later - earlier is strictly above the threshold.
    // Callers only rely on the result where later >= earlier, so a wrapped difference is never used.
    function automatic logic exceeds(t_time later, t_time earlier, t_gap thr);
        t_time diff;
        diff = later - earlier;
        return diff > {{(TIME_BITS-GAP_BITS){1'b0}}, thr};
    endfunction

endpackage

### hdl/bpec_core.sv
// Poll state (previous level, last pressed/released times, long flag) and the
// flag logic for one poll. Depends on bpec_pkg.
module bpec_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  bpec_pkg::t_time i_time,
    input  logic            i_level,
    input  bpec_pkg::t_gaps i_gaps,
    output bpec_pkg::t_flags o_flags
);
    import bpec_pkg::*;

    logic  r_prev_level, n_prev_level;
    t_time r_pressed_t,  n_pressed_t;
    t_time r_released_t, n_released_t;
    logic  r_long_seen,  n_long_seen;

    logic  changed;
    logic  rev;
    logic  end_long, end_short;
    logic  now_pressed, now_released;
    logic  now_long;
    logic  seen_eff;
    logic  entered;

    always_comb begin
        changed = (i_level != r_prev_level);

        // Reversal and the length of the state that just ended, from the old times.
        if (i_level) begin
            rev       = (r_pressed_t < r_released_t);
            end_long  = exceeds(r_released_t, r_pressed_t, i_gaps.long_gap);
            end_short = exceeds(r_released_t, r_pressed_t, i_gaps.short_gap);
            n_pressed_t  = i_time;
            n_released_t = r_released_t;
        end else begin
            rev       = (r_pressed_t > r_released_t);
            end_long  = exceeds(r_pressed_t, r_released_t, i_gaps.long_gap);
            end_short = exceeds(r_pressed_t, r_released_t, i_gaps.short_gap);
            n_pressed_t  = r_pressed_t;
            n_released_t = i_time;
        end

        // Current state from the updated times.
        now_pressed  = (n_pressed_t > n_released_t);
        now_released = (n_pressed_t < n_released_t);
        if (now_pressed) begin
            now_long = exceeds(n_pressed_t, n_released_t, i_gaps.long_gap);
        end else if (now_released) begin
            now_long = exceeds(n_released_t, n_pressed_t, i_gaps.long_gap);
        end else begin
            now_long = 1'b0;
        end

        seen_eff     = changed ? 1'b0 : r_long_seen;
        entered      = now_long && !seen_eff;
        n_long_seen  = seen_eff || now_long;
        n_prev_level = i_level;

        o_flags.level_changed        = changed;
        o_flags.state_reversed       = rev;
        o_flags.became_pressed       = rev && i_level;
        o_flags.became_released      = rev && !i_level;
        o_flags.long_release_ended   = rev && i_level && end_long;
        o_flags.short_release_ended  = rev && i_level && !end_long && end_short;
        o_flags.long_press_ended     = rev && !i_level && end_long;
        o_flags.short_press_ended    = rev && !i_level && !end_long && end_short;
        o_flags.long_press_entered   = entered && now_pressed;
        o_flags.long_press_holding   = now_long && now_pressed;
        o_flags.long_release_entered = entered && now_released;
        o_flags.long_release_holding = now_long && now_released;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_pressed_t  <= '0;
            r_released_t <= '0;
            r_long_seen  <= 1'b0;
        end else if (i_fire) begin
            r_prev_level <= n_prev_level;
            r_pressed_t  <= n_pressed_t;
            r_released_t <= n_released_t;
            r_long_seen  <= n_long_seen;
        end
    end

endmodule

### hdl/button_press_event_classifier.sv
// Top level of the button press event classifier: configuration registers,
// request handshakes and the result register. Depends on bpec_pkg and bpec_core.

// The classifier takes one poll request per clock cycle while o_ready is high:
// a 48-bit microsecond timestamp and the pin level (1 pressed, 0 released).
// Each accepted request yields exactly one result of twelve event flags,
// registered and presented in the cycle after acceptance. The rate is one
// request per cycle while the result side does not stall, set by the single
// pass from the stored poll state through the duration compares into the
// result register; the stored state is updated in the same cycle, so the next
// request sees it at once. A new request is taken whenever the result register
// is empty or its result is being taken in the same cycle, so a stall on the
// result side holds the input side only while a result is waiting. Duration
// tests are strict greater-than against long_gap_us (register 0, reset 1000000)
// and short_gap_us (register 1, reset 50000). Timestamps are expected to be
// monotonic; there is no wrap handling. The user must write registers through
// the write port only while no request is in flight; no check enforces it.
module button_press_event_classifier (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [bpec_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [bpec_pkg::GAP_BITS-1:0]     i_cfg_data,
    // Poll request channel.
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [bpec_pkg::TIME_BITS-1:0]    i_sample_time_us,
    input  logic                  i_pin_level,
    // Result channel.
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_level_changed,
    output logic                  o_state_reversed,
    output logic                  o_became_pressed,
    output logic                  o_became_released,
    output logic                  o_long_release_ended,
    output logic                  o_short_release_ended,
    output logic                  o_long_press_ended,
    output logic                  o_short_press_ended,
    output logic                  o_long_press_entered,
    output logic                  o_long_press_holding,
    output logic                  o_long_release_entered,
    output logic                  o_long_release_holding
);
    import bpec_pkg::*;

    t_gaps  r_gaps;
    t_flags core_flags;
    t_flags r_flags;
    logic   r_out_valid;
    logic   in_fire;

    // A request is taken when the result register is free or draining.
    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    // Threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gaps.long_gap  <= GAP_BITS'(1000000);
            r_gaps.short_gap <= GAP_BITS'(50000);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LONG_GAP:  r_gaps.long_gap  <= i_cfg_data;
                CFG_SHORT_GAP: r_gaps.short_gap <= i_cfg_data;
            endcase
        end
    end

    bpec_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_time  (i_sample_time_us),
        .i_level (i_pin_level),
        .i_gaps  (r_gaps),
        .o_flags (core_flags)
    );

    // Result register: loaded on every accepted request, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_flags <= core_flags;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_level_changed        = r_flags.level_changed;
    assign o_state_reversed       = r_flags.state_reversed;
    assign o_became_pressed       = r_flags.became_pressed;
    assign o_became_released      = r_flags.became_released;
    assign o_long_release_ended   = r_flags.long_release_ended;
    assign o_short_release_ended  = r_flags.short_release_ended;
    assign o_long_press_ended     = r_flags.long_press_ended;
    assign o_short_press_ended    = r_flags.short_press_ended;
    assign o_long_press_entered   = r_flags.long_press_entered;
    assign o_long_press_holding   = r_flags.long_press_holding;
    assign o_long_release_entered = r_flags.long_release_entered;
    assign o_long_release_holding = r_flags.long_release_holding;

`ifndef NO_ASSERTIONS
    // Every accepted request leaves a result waiting in the next cycle.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_valid)
        else $error("accepted request produced no result");

    // A pressed poll can never report the end of a press.
    a_pressed_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_pin_level |=>
            !(o_became_released || o_long_press_ended || o_short_press_ended))
        else $error("pressed poll reported a press ending");

    // A released poll can never report the end of a release.
    a_released_no_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !i_pin_level |=>
            !(o_became_pressed || o_long_release_ended || o_short_release_ended))
        else $error("released poll reported a release ending");
`endif

endmodule
